### rtl/core/rpcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_pkg
// Shared widths, codes and controller/datapath interface types of the
// rc pulse channel decoder.
// ----------------------------------------------------------------------------
package rpcd_pkg;

  localparam int TS_W      = 32;
  localparam int WIDTH_W   = 12;
  localparam int CNT_W     = 16;
  localparam int AMP_W     = 15;
  localparam int MODE_W    = 2;
  localparam int CMD_W     = 3;
  localparam int ZL_W      = 32;
  localparam int SCALE_W   = 32;
  localparam int VALUE_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = ZL_W + 2;
  localparam int PROD_W    = 2 * SCALE_W;

  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // width clamp rule
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 12'd2200;
  localparam logic [WIDTH_W-1:0] WIDTH_SUBST = 12'd1500;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN_RST = WIDTH_SUBST;

  // amplitude / 10 as multiply by reciprocal, exact over the amplitude range
  localparam int DB_RECIP_W = 16;
  localparam logic [DB_RECIP_W-1:0] DB_RECIP = 16'd52429;
  localparam int DB_SHIFT   = 19;
  localparam int DB_PROD_W  = AMP_W + DB_RECIP_W;
  localparam int DB_W       = DB_PROD_W - DB_SHIFT;

  localparam logic [AMP_W-1:0] AMP_RST = 15'd500;

  // request commands
  localparam logic [CMD_W-1:0] CMD_PIN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_AVG   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RANGE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COEF  = 3'd4;

  // channel modes
  localparam logic [MODE_W-1:0] MODE_PROP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SW2  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SW3  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMP  = 1'd1;

  typedef enum logic [1:0] {
    DIV_TGT_AVG,
    DIV_TGT_ABOVE,
    DIV_TGT_BELOW
  } div_tgt_t;

  typedef struct packed {
    logic     load_in;
    logic     exec_simple;
    logic     div_start;
    logic     quot_wr;
    logic     quot_clr;
    div_tgt_t div_tgt;
    logic     t_load;
    logic     mul_load;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             count_nz;
    logic             above_pos;
    logic             below_pos;
    logic             div_done;
    logic             out_free;
  } dp_status_t;

endpackage

### rtl/core/rpcd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpcd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpcd_pkg::DIV_W-1:0] dividend,
  input  logic [rpcd_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [rpcd_pkg::DIV_W-1:0] quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [rpcd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [rpcd_pkg::DIV_W-1:0]     num_r;
  logic [rpcd_pkg::DIV_W-1:0]     rem_r;
  logic [rpcd_pkg::DIV_W-1:0]     den_r;

  logic [rpcd_pkg::DIV_W:0]       rem_sh;
  logic                           ge;
  logic [rpcd_pkg::DIV_W:0]       rem_sub;
  logic [rpcd_pkg::DIV_W-1:0]     rem_nxt;
  logic [rpcd_pkg::DIV_W-1:0]     num_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[rpcd_pkg::DIV_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = ge ? rem_sub[rpcd_pkg::DIV_W-1:0] : rem_sh[rpcd_pkg::DIV_W-1:0];
    num_nxt = {num_r[rpcd_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rpcd_pkg::DIV_CNT_W'(rpcd_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

### rtl/core/rpcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_dp
// Datapath: request registers, channel state, shared divider, value
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module rpcd_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rpcd_pkg::ctrl_cmd_t                  cmd,
  output rpcd_pkg::dp_status_t                 status,
  input  logic [rpcd_pkg::CMD_W-1:0]           in_command,
  input  logic                                 in_pin_level,
  input  logic [rpcd_pkg::TS_W-1:0]            in_timestamp_us,
  input  logic [rpcd_pkg::CNT_W-1:0]           in_sample_count,
  input  logic                                 cfg_wr_en,
  input  logic [rpcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpcd_pkg::CFG_DAT_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rpcd_pkg::WIDTH_W-1:0]         out_pulse_width,
  output logic signed [rpcd_pkg::VALUE_W-1:0]  out_value_q8,
  output logic                                 out_value_valid
);

  // request registers
  logic [rpcd_pkg::CMD_W-1:0]   cmd_r;
  logic                         level_r;
  logic [rpcd_pkg::TS_W-1:0]    ts_r;
  logic [rpcd_pkg::CNT_W-1:0]   count_r;

  // configuration
  logic [rpcd_pkg::MODE_W-1:0]  mode_r;
  logic [rpcd_pkg::AMP_W-1:0]   amp_r;

  // channel state
  logic [rpcd_pkg::TS_W-1:0]    rise_time_r;
  logic [rpcd_pkg::WIDTH_W-1:0] width_latest_r;
  logic [rpcd_pkg::ZL_W-1:0]    zero_level_r;
  logic [rpcd_pkg::WIDTH_W-1:0] width_min_r;
  logic [rpcd_pkg::WIDTH_W-1:0] width_max_r;
  logic [rpcd_pkg::SCALE_W-1:0] scale_above_r;
  logic [rpcd_pkg::SCALE_W-1:0] scale_below_r;

  // value pipeline
  logic signed [rpcd_pkg::DIFF_W-1:0] t_r;
  logic [rpcd_pkg::PROD_W-1:0]        prod_r;

  // output register
  logic                                out_valid_r;
  logic [rpcd_pkg::WIDTH_W-1:0]        out_width_r;
  logic signed [rpcd_pkg::VALUE_W-1:0] out_value_r;
  logic                                out_vv_r;

  logic [15:0]                   raw_w;
  logic [rpcd_pkg::WIDTH_W-1:0]  meas_w;
  logic [rpcd_pkg::ZL_W:0]       d_above;
  logic [rpcd_pkg::ZL_W:0]       d_below;
  logic [rpcd_pkg::DIV_W-1:0]    div_dividend;
  logic [rpcd_pkg::DIV_W-1:0]    div_divisor;
  logic                          div_done;
  logic [rpcd_pkg::DIV_W-1:0]    div_quot;
  logic [rpcd_pkg::SCALE_W-1:0]  quot_val;

  logic signed [rpcd_pkg::DIFF_W-1:0] t_nxt;
  logic signed [rpcd_pkg::DIFF_W-1:0] t_neg;
  logic                               t_is_neg;
  logic [rpcd_pkg::SCALE_W-1:0]       mag;
  logic [rpcd_pkg::SCALE_W-1:0]       scale_sel;

  logic [rpcd_pkg::DB_PROD_W-1:0]     db_prod;
  logic [rpcd_pkg::DB_W-1:0]          deadband;
  logic signed [rpcd_pkg::DIFF_W-1:0] db_s;
  logic [rpcd_pkg::VALUE_W-1:0]       amp_q8;
  logic [rpcd_pkg::VALUE_W-1:0]       prop_mag;
  logic                               prop_big;
  logic [rpcd_pkg::VALUE_W-1:0]       value_nxt;
  logic                               vv_nxt;

  // pulse width and divider operands
  always_comb begin
    raw_w  = 16'(ts_r - rise_time_r);
    meas_w = (raw_w > {4'b0, rpcd_pkg::WIDTH_LIMIT}) ? rpcd_pkg::WIDTH_SUBST
                                                     : raw_w[rpcd_pkg::WIDTH_W-1:0];
    d_above = {21'b0, width_max_r} - {1'b0, zero_level_r};
    d_below = {1'b0, zero_level_r} - {21'b0, width_min_r};
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd.div_tgt)
      rpcd_pkg::DIV_TGT_AVG: begin
        div_dividend = zero_level_r;
        div_divisor  = {16'b0, count_r};
      end
      rpcd_pkg::DIV_TGT_ABOVE: begin
        div_dividend = {1'b0, amp_r, {rpcd_pkg::FRAC_BITS{1'b0}}};
        div_divisor  = d_above[rpcd_pkg::DIV_W-1:0];
      end
      rpcd_pkg::DIV_TGT_BELOW: begin
        div_dividend = {1'b0, amp_r, {rpcd_pkg::FRAC_BITS{1'b0}}};
        div_divisor  = d_below[rpcd_pkg::DIV_W-1:0];
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
    quot_val = cmd.quot_clr ? '0 : div_quot;
  end

  rpcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // signed difference and proportional operands
  always_comb begin
    t_nxt    = $signed({22'b0, width_latest_r}) - $signed({2'b0, zero_level_r});
    t_is_neg = t_r[rpcd_pkg::DIFF_W-1];
    t_neg    = -t_r;
    // very negative difference is limited to -2^31
    if (t_is_neg && (t_neg > $signed(34'h0_8000_0000))) begin
      mag = 32'h8000_0000;
    end else if (t_is_neg) begin
      mag = t_neg[rpcd_pkg::SCALE_W-1:0];
    end else begin
      mag = t_r[rpcd_pkg::SCALE_W-1:0];
    end
    scale_sel = t_is_neg ? scale_below_r : scale_above_r;
  end

  // result value
  always_comb begin
    db_prod  = {{rpcd_pkg::DB_RECIP_W{1'b0}}, amp_r} *
               {{rpcd_pkg::AMP_W{1'b0}}, rpcd_pkg::DB_RECIP};
    deadband = db_prod[rpcd_pkg::DB_PROD_W-1:rpcd_pkg::DB_SHIFT];
    db_s     = $signed({{(rpcd_pkg::DIFF_W - rpcd_pkg::DB_W){1'b0}}, deadband});
    amp_q8   = {1'b0, amp_r, 8'b0};
    // product of 2^31 or more saturates after the q16 to q8 shift
    prop_big = |prod_r[rpcd_pkg::PROD_W-1:31];
    prop_mag = {1'b0, prod_r[30:8]};
    vv_nxt   = 1'b1;
    value_nxt = '0;
    unique case (mode_r)
      rpcd_pkg::MODE_PROP: begin
        if (t_is_neg) begin
          value_nxt = prop_big ? 24'h80_0000 : -prop_mag;
        end else begin
          value_nxt = prop_big ? 24'h7F_FFFF : prop_mag;
        end
      end
      rpcd_pkg::MODE_SW2: begin
        value_nxt = t_is_neg ? -amp_q8 : amp_q8;
      end
      rpcd_pkg::MODE_SW3: begin
        if (t_r > db_s) begin
          value_nxt = amp_q8;
        end else if (t_r < -db_s) begin
          value_nxt = -amp_q8;
        end else begin
          value_nxt = '0;
        end
      end
      default: begin
        vv_nxt    = 1'b0;
        value_nxt = '0;
      end
    endcase
  end

  // configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= rpcd_pkg::MODE_PROP;
      amp_r          <= rpcd_pkg::AMP_RST;
      rise_time_r    <= '0;
      width_latest_r <= '0;
      zero_level_r   <= '0;
      width_min_r    <= rpcd_pkg::WIDTH_MIN_RST;
      width_max_r    <= '0;
      scale_above_r  <= '0;
      scale_below_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rpcd_pkg::CFG_IDX_MODE: mode_r <= cfg_data[rpcd_pkg::MODE_W-1:0];
          rpcd_pkg::CFG_IDX_AMP:  amp_r  <= cfg_data[rpcd_pkg::AMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec_simple) begin
        case (cmd_r)
          rpcd_pkg::CMD_PIN: begin
            if (level_r) begin
              rise_time_r <= ts_r;
            end else begin
              width_latest_r <= meas_w;
            end
          end
          rpcd_pkg::CMD_ADD: begin
            zero_level_r <= zero_level_r + {20'b0, width_latest_r};
          end
          rpcd_pkg::CMD_RANGE: begin
            if (width_latest_r > width_max_r) begin
              width_max_r <= width_latest_r;
            end
            if (width_latest_r < width_min_r) begin
              width_min_r <= width_latest_r;
            end
          end
          default: ;
        endcase
      end
      if (cmd.quot_wr || cmd.quot_clr) begin
        unique case (cmd.div_tgt)
          rpcd_pkg::DIV_TGT_AVG:   zero_level_r  <= quot_val;
          rpcd_pkg::DIV_TGT_ABOVE: scale_above_r <= quot_val;
          rpcd_pkg::DIV_TGT_BELOW: scale_below_r <= quot_val;
          default: ;
        endcase
      end
    end
  end

  // request capture, value pipeline and output data registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_command;
      level_r <= in_pin_level;
      ts_r    <= in_timestamp_us;
      count_r <= in_sample_count;
    end
    if (cmd.t_load) begin
      t_r <= t_nxt;
    end
    if (cmd.mul_load) begin
      prod_r <= {32'b0, mag} * {32'b0, scale_sel};
    end
    if (cmd.out_load) begin
      out_width_r <= width_latest_r;
      out_value_r <= value_nxt;
      out_vv_r    <= vv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status.item_cmd  = cmd_r;
    status.count_nz  = |count_r;
    status.above_pos = !d_above[rpcd_pkg::ZL_W] && (|d_above);
    status.below_pos = !d_below[rpcd_pkg::ZL_W] && (|d_below);
    status.div_done  = div_done;
    status.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_width = out_width_r;
  assign out_value_q8    = out_value_r;
  assign out_value_valid = out_vv_r;

endmodule

### rtl/core/rpcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcd_ctrl
// Controller: sequences each request through execute, divide (average and
// coefficient requests, where needed), value and result steps of the datapath.
// ----------------------------------------------------------------------------
module rpcd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rpcd_pkg::dp_status_t status,
  output rpcd_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT_AVG,
    S_COEF_A,
    S_WAIT_A,
    S_COEF_B,
    S_WAIT_B,
    S_TDIFF,
    S_MUL,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_tgt = rpcd_pkg::DIV_TGT_AVG;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.item_cmd)
          rpcd_pkg::CMD_AVG: begin
            if (status.count_nz) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_WAIT_AVG;
            end else begin
              state_nxt = S_TDIFF;
            end
          end
          rpcd_pkg::CMD_COEF: begin
            state_nxt = S_COEF_A;
          end
          default: begin
            cmd.exec_simple = 1'b1;
            state_nxt       = S_TDIFF;
          end
        endcase
      end
      S_WAIT_AVG: begin
        if (status.div_done) begin
          cmd.quot_wr = 1'b1;
          state_nxt   = S_TDIFF;
        end
      end
      S_COEF_A: begin
        cmd.div_tgt = rpcd_pkg::DIV_TGT_ABOVE;
        if (status.above_pos) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT_A;
        end else begin
          cmd.quot_clr = 1'b1;
          state_nxt    = S_COEF_B;
        end
      end
      S_WAIT_A: begin
        cmd.div_tgt = rpcd_pkg::DIV_TGT_ABOVE;
        if (status.div_done) begin
          cmd.quot_wr = 1'b1;
          state_nxt   = S_COEF_B;
        end
      end
      S_COEF_B: begin
        cmd.div_tgt = rpcd_pkg::DIV_TGT_BELOW;
        if (status.below_pos) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT_B;
        end else begin
          cmd.quot_clr = 1'b1;
          state_nxt    = S_TDIFF;
        end
      end
      S_WAIT_B: begin
        cmd.div_tgt = rpcd_pkg::DIV_TGT_BELOW;
        if (status.div_done) begin
          cmd.quot_wr = 1'b1;
          state_nxt   = S_TDIFF;
        end
      end
      S_TDIFF: begin
        cmd.t_load = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### rtl/core/rc_pulse_channel_decoder_unit.sv
`timescale 1ns / 1ps
// sequence: out_valid rises after a request passes the execute, time difference, multiply
//   and result states, with divider waits for nonzero-count averages and positive ranges
// throughput: one request at a time, next one taken the cycle after its result is loaded;
//   the result state holds while out_stall blocks a pending output
// reset: synchronous active low, clears control, resets config and calibration registers
// ----------------------------------------------------------------------------
// rc_pulse_channel_decoder_unit
// Rc servo pulse width decoder with calibration and q8 channel value.
// ----------------------------------------------------------------------------
module rc_pulse_channel_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rpcd_pkg::CMD_W-1:0]           in_command,
  input  logic                                 in_pin_level,
  input  logic [rpcd_pkg::TS_W-1:0]            in_timestamp_us,
  input  logic [rpcd_pkg::CNT_W-1:0]           in_sample_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rpcd_pkg::WIDTH_W-1:0]         out_pulse_width,
  output logic signed [rpcd_pkg::VALUE_W-1:0]  out_value_q8,
  output logic                                 out_value_valid,
  input  logic                                 cfg_wr_en,
  input  logic [rpcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpcd_pkg::CFG_DAT_W-1:0]       cfg_data
);

  rpcd_pkg::ctrl_cmd_t  cmd;
  rpcd_pkg::dp_status_t status;

  rpcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rpcd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_command),
    .in_pin_level    (in_pin_level),
    .in_timestamp_us (in_timestamp_us),
    .in_sample_count (in_sample_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pulse_width (out_pulse_width),
    .out_value_q8    (out_value_q8),
    .out_value_valid (out_value_valid)
  );

endmodule
